// File: rtl/glyph_atlas_scaled_blitter_macros.svh
// ---------------------------------------------------------------------------
// Glyph atlas scaled blitter: assertion macros
// Clocked on clk; the first form is disabled in reset, the second is not.
// ---------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SCALED_BLITTER_MACROS_SVH
`define GLYPH_ATLAS_SCALED_BLITTER_MACROS_SVH
`ifndef ASSERT_OFF
`define GASB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GASB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GASB_ASSERT(lbl, prop, msg)
`define GASB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: rtl/gasb_pkg.sv
// ---------------------------------------------------------------------------
// gasb_pkg
// Types and constants shared by the glyph atlas scaled blitter modules.
// ---------------------------------------------------------------------------
package gasb_pkg;

  localparam int MAX_GLYPH_WIDTH = 1024;
  localparam int MAX_SCALE       = 4;

  localparam int DESC_DEPTH_DEF = 2;
  localparam int RES_DEPTH_DEF  = 4;

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // The scale register is 3 bits wide, so the effective scale never exceeds 7.
  localparam logic [2:0]  SCALE_CAP = 3'(MAX_SCALE > 7 ? 7 : MAX_SCALE);
  localparam logic [10:0] GW_CAP    = 11'(MAX_GLYPH_WIDTH > 2047 ? 2047 : MAX_GLYPH_WIDTH);

  // Destination coordinate widths for the largest register values.
  localparam int BX_W  = 18;
  localparam int BY_W  = 15;
  localparam int IDX_W = 26;

  localparam logic [10:0] CELL_WIDTH_RST  = 11'd1;
  localparam logic [7:0]  FONT_HEIGHT_RST = 8'd1;
  localparam logic [2:0]  PADDING_RST     = 3'd0;
  localparam logic [2:0]  SCALE_RST       = 3'd1;
  localparam logic [13:0] STRIDE_RST      = 14'd16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CELL_WIDTH  = 3'd0,
    REG_FONT_HEIGHT = 3'd1,
    REG_PADDING     = 3'd2,
    REG_SCALE       = 3'd3,
    REG_STRIDE      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] cell_width;
    logic [7:0]  font_height;
    logic [2:0]  cell_padding;
    logic [2:0]  scale_factor;
    logic [13:0] atlas_row_pixels;
  } cfg_t;

  // One source pixel, resolved to the top-left corner of its block.
  typedef struct packed {
    logic [BX_W-1:0] base_x;
    logic [BY_W-1:0] base_y;
    logic [2:0]      scale;
    logic            ink;
    logic            shadow;
    logic            done;
  } desc_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic             ink_write;
    logic             shadow_set;
    logic             run_last;
    logic             glyph_done;
  } res_t;

endpackage

// File: rtl/gasb_fifo.sv
// ---------------------------------------------------------------------------
// gasb_fifo
// Small register queue with show-ahead read, full, empty and fill level.
// ---------------------------------------------------------------------------
module gasb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (level == LW'(DEPTH));
  assign empty   = (level == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        level <= level + 1'b1;
      end else if (rd_ok && !wr_ok) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/gasb_front.sv
// ---------------------------------------------------------------------------
// gasb_front
// Accepts source pixels, steps the column and row counters and resolves each
// pixel to the atlas corner of its replicated block.
// ---------------------------------------------------------------------------
module gasb_front (
  input  logic           clk,
  input  logic           rst,
  input  gasb_pkg::cfg_t cfg,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     char_code,
  input  logic [10:0]    glyph_width,
  input  logic [7:0]     pixel_value,
  output logic           desc_push,
  output gasb_pkg::desc_t desc,
  input  logic           desc_full
);
  import gasb_pkg::*;

  logic        accept;
  logic [9:0]  source_column;
  logic [7:0]  source_row;
  logic [10:0] gw;
  logic [7:0]  fh;
  logic [10:0] ncol;
  logic [8:0]  nrow;
  logic        row_end;
  logic        glyph_end;

  logic        stg_valid;
  logic [7:0]  stg_code;
  logic [9:0]  stg_col;
  logic [7:0]  stg_row;
  logic        stg_ink;
  logic        stg_shadow;
  logic        stg_done;

  logic [2:0]  scale_next;
  logic [2:0]  scale;
  logic [13:0] pitch_x;
  logic [10:0] pitch_y;
  logic [5:0]  pad_s;

  assign accept    = push && !full;
  assign full      = stg_valid && desc_full;
  assign desc_push = stg_valid && !desc_full;

  always_comb begin
    if (glyph_width == '0) begin
      gw = 11'd1;
    end else if (glyph_width > GW_CAP) begin
      gw = GW_CAP;
    end else begin
      gw = glyph_width;
    end
    fh        = (cfg.font_height == '0) ? 8'd1 : cfg.font_height;
    ncol      = {1'b0, source_column} + 11'd1;
    nrow      = {1'b0, source_row} + 9'd1;
    row_end   = (ncol >= gw);
    glyph_end = row_end && (nrow >= {1'b0, fh});
    if (cfg.scale_factor == '0) begin
      scale_next = 3'd1;
    end else if (cfg.scale_factor > SCALE_CAP) begin
      scale_next = SCALE_CAP;
    end else begin
      scale_next = cfg.scale_factor;
    end
  end

  // Cell geometry follows the registers in the next cycle; the holding stage
  // gives it that cycle before the first use.
  always_ff @(posedge clk) begin
    scale   <= scale_next;
    pitch_x <= ({3'b0, cfg.cell_width} + {10'b0, cfg.cell_padding, 1'b0}) *
               {11'b0, scale_next};
    pitch_y <= ({3'b0, cfg.font_height} + {7'b0, cfg.cell_padding, 1'b0}) *
               {8'b0, scale_next};
    pad_s   <= {3'b0, cfg.cell_padding} * {3'b0, scale_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row    <= '0;
      stg_valid     <= 1'b0;
    end else begin
      if (accept) begin
        source_column <= row_end ? '0 : ncol[9:0];
        if (row_end) begin
          source_row <= glyph_end ? '0 : nrow[7:0];
        end
        stg_valid <= 1'b1;
      end else if (desc_push) begin
        stg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_code   <= char_code;
      stg_col    <= source_column;
      stg_row    <= source_row;
      stg_ink    <= (pixel_value > 8'd1);
      stg_shadow <= (pixel_value == 8'd1);
      stg_done   <= glyph_end;
    end
  end

  // The low code nibble is the grid column, the high nibble the grid row.
  always_comb begin
    desc.base_x = BX_W'(stg_code[3:0]) * BX_W'(pitch_x) + BX_W'(pad_s) +
                  BX_W'(stg_col) * BX_W'(scale);
    desc.base_y = BY_W'(stg_code[7:4]) * BY_W'(pitch_y) + BY_W'(pad_s) +
                  BY_W'(stg_row) * BY_W'(scale);
    desc.scale  = scale;
    desc.ink    = stg_ink;
    desc.shadow = stg_shadow;
    desc.done   = stg_done;
  end

endmodule

// File: rtl/gasb_back.sv
// ---------------------------------------------------------------------------
// gasb_back
// Walks each block row by row, one atlas write per cycle while the result queue
// has room, and queues the resulting writes for the consumer.
// ---------------------------------------------------------------------------
module gasb_back #(
  parameter int RES_DEPTH = gasb_pkg::RES_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [13:0]     stride,
  input  gasb_pkg::desc_t desc,
  input  logic            desc_empty,
  output logic            desc_pop,
  input  logic            pop,
  output logic            empty,
  output gasb_pkg::res_t  res
);
  import gasb_pkg::*;

  localparam int LW = $clog2(RES_DEPTH + 1);

  desc_t            cur;
  logic             active;
  logic [2:0]       dx;
  logic [2:0]       dy;
  logic             col_last;
  logic             last;
  logic             issue;
  logic             room;
  logic [LW:0]      occ;
  logic [LW-1:0]    res_level;

  logic [BY_W-1:0]  row_y;
  logic [BX_W-1:0]  col_x;
  logic [BY_W+13:0] prod_full;

  logic             p1_valid;
  logic [IDX_W-1:0] p1_prod;
  logic [BX_W-1:0]  p1_x;
  logic             p1_ink;
  logic             p1_shadow;
  logic             p1_last;
  logic             p1_done;
  res_t             res_in;

  // Writes in flight count against the queue so that none is ever dropped.
  assign occ      = {1'b0, res_level} + {{LW{1'b0}}, p1_valid};
  assign room     = occ < (LW + 1)'(RES_DEPTH);
  assign issue    = active && room;
  assign col_last = (dx == cur.scale - 3'd1);
  assign last     = col_last && (dy == cur.scale - 3'd1);
  assign desc_pop = !desc_empty && (!active || (issue && last));

  assign row_y     = cur.base_y + BY_W'(dy);
  assign col_x     = cur.base_x + BX_W'(dx);
  assign prod_full = row_y * stride;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      p1_valid <= 1'b0;
    end else begin
      if (desc_pop) begin
        active <= 1'b1;
      end else if (issue && last) begin
        active <= 1'b0;
      end
      p1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      cur <= desc;
      dx  <= '0;
      dy  <= '0;
    end else if (issue) begin
      if (col_last) begin
        dx <= '0;
        dy <= dy + 3'd1;
      end else begin
        dx <= dx + 3'd1;
      end
    end
    if (issue) begin
      p1_prod   <= prod_full[IDX_W-1:0];
      p1_x      <= col_x;
      p1_ink    <= cur.ink;
      p1_shadow <= cur.shadow;
      p1_last   <= last;
      p1_done   <= cur.done;
    end
  end

  always_comb begin
    res_in.pixel_index = p1_prod + IDX_W'(p1_x);
    res_in.ink_write   = p1_ink;
    res_in.shadow_set  = p1_shadow;
    res_in.run_last    = p1_last;
    res_in.glyph_done  = p1_done;
  end

  gasb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (p1_valid),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res),
    .full    (),
    .empty   (empty),
    .level   (res_level)
  );

endmodule

// File: rtl/glyph_atlas_scaled_blitter.sv
// ---------------------------------------------------------------------------
// glyph_atlas_scaled_blitter
// Copies glyph source pixels into a 16 by 16 atlas grid with nearest-neighbor
// scaling: one queued atlas write per destination pixel.
// ---------------------------------------------------------------------------
// A pixel's first write passes the holding stage, descriptor queue, walker and
// address register into the result queue. One atlas write per cycle while that
// queue has room: scale*scale writes a pixel (1 to 16 at the default scale cap).
// The front end and its two-entry descriptor queue take pixels while the back
// end works. Synchronous reset empties all queues, zeroes the column and row
// counters and restores the register defaults; no clearing pass is needed.
module glyph_atlas_scaled_blitter #(
  parameter int DESC_DEPTH = gasb_pkg::DESC_DEPTH_DEF,
  parameter int RES_DEPTH  = gasb_pkg::RES_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gasb_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [gasb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      char_code,
  input  logic [10:0]                     glyph_width,
  input  logic [7:0]                      pixel_value,
  output logic                            empty,
  input  logic                            pop,
  output logic [gasb_pkg::IDX_W-1:0]      pixel_index,
  output logic                            ink_write,
  output logic                            shadow_set,
  output logic                            run_last,
  output logic                            glyph_done
);
  import gasb_pkg::*;

  cfg_t  cfg;
  desc_t desc_in;
  desc_t desc_out;
  logic  desc_push;
  logic  desc_pop;
  logic  desc_full;
  logic  desc_empty;
  res_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width       <= CELL_WIDTH_RST;
      cfg.font_height      <= FONT_HEIGHT_RST;
      cfg.cell_padding     <= PADDING_RST;
      cfg.scale_factor     <= SCALE_RST;
      cfg.atlas_row_pixels <= STRIDE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CELL_WIDTH:  cfg.cell_width       <= cfg_data[10:0];
        REG_FONT_HEIGHT: cfg.font_height      <= cfg_data[7:0];
        REG_PADDING:     cfg.cell_padding     <= cfg_data[2:0];
        REG_SCALE:       cfg.scale_factor     <= cfg_data[2:0];
        REG_STRIDE:      cfg.atlas_row_pixels <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  gasb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .char_code   (char_code),
    .glyph_width (glyph_width),
    .pixel_value (pixel_value),
    .desc_push   (desc_push),
    .desc        (desc_in),
    .desc_full   (desc_full)
  );

  gasb_fifo #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (DESC_DEPTH)
  ) u_desc_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (desc_push),
    .wr_data (desc_in),
    .rd_en   (desc_pop),
    .rd_data (desc_out),
    .full    (desc_full),
    .empty   (desc_empty),
    .level   ()
  );

  gasb_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .stride     (cfg.atlas_row_pixels),
    .desc       (desc_out),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .pop        (pop),
    .empty      (empty),
    .res        (res)
  );

  assign pixel_index = res.pixel_index;
  assign ink_write   = res.ink_write;
  assign shadow_set  = res.shadow_set;
  assign run_last    = res.run_last;
  assign glyph_done  = res.glyph_done;

`include "glyph_atlas_scaled_blitter_macros.svh"

  `GASB_ASSERT_RST(a_reset_idle, rst |=> (empty && !full), "queues not idle after reset")
  `GASB_ASSERT(a_desc_no_overflow, desc_push |-> !desc_full, "descriptor pushed while full")
  `GASB_ASSERT(a_desc_no_underflow, desc_pop |-> !desc_empty, "descriptor taken while empty")

endmodule
